[design/mlpq_pkg.sv]
// Shared constants, codes and control types of the multi-level priority queue.
package mlpq_pkg;

   localparam int LEVELS     = 4;
   localparam int DEPTH      = 16;
   localparam int WORD_BITS  = 32;
   localparam int LEVEL_BITS = 2;
   localparam int PTR_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int SLOTS      = LEVELS * DEPTH;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int REQ_TDATA_BITS = ((LEVEL_BITS + WORD_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((WORD_BITS + LEVEL_BITS + 7) / 8) * 8;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_REMOVED   = 2'd1,
      STATUS_OVERFLOW  = 2'd2,
      STATUS_UNDERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EMIT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic emit;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic out_free;
   } dp_stat_type;

endpackage

[design/mlpq_ctrl.sv]
// Controller state machine of the multi-level priority queue.
module mlpq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mlpq_pkg::dp_stat_type dp_stat,
   output mlpq_pkg::cmd_type    cmd
);

   mlpq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mlpq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         mlpq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = mlpq_pkg::ST_EXEC;
            end
         end
         mlpq_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = mlpq_pkg::ST_EMIT;
         end
         mlpq_pkg::ST_EMIT: begin
            // wait until the output register can take the result
            if (dp_stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = mlpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mlpq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[design/mlpq_dp.sv]
// Datapath of the multi-level priority queue: pointers, counts, slot memory, result register.
module mlpq_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mlpq_pkg::cmd_type                     cmd,
   output mlpq_pkg::dp_stat_type                 dp_stat,
   input  logic                                  req_func,
   input  logic [mlpq_pkg::LEVEL_BITS-1:0]       req_level,
   input  logic signed [mlpq_pkg::WORD_BITS-1:0] req_value,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [1:0]                            rsp_status,
   output logic signed [mlpq_pkg::WORD_BITS-1:0] rsp_value,
   output logic [mlpq_pkg::LEVEL_BITS-1:0]       rsp_level
);

   logic [mlpq_pkg::WORD_BITS-1:0] slot_mem [mlpq_pkg::SLOTS];

   logic                                 func_ff;
   logic [mlpq_pkg::LEVEL_BITS-1:0]      level_ff;
   logic [mlpq_pkg::WORD_BITS-1:0]       value_ff;

   logic [mlpq_pkg::PTR_BITS-1:0]        head_ff [mlpq_pkg::LEVELS];
   logic [mlpq_pkg::PTR_BITS-1:0]        tail_ff [mlpq_pkg::LEVELS];
   logic [mlpq_pkg::CNT_BITS-1:0]        fill_ff [mlpq_pkg::LEVELS];

   mlpq_pkg::status_type                 status_ff, status_in;
   logic [mlpq_pkg::LEVEL_BITS-1:0]      from_ff;
   logic [mlpq_pkg::WORD_BITS-1:0]       rd_data_ff;

   logic                                 rsp_valid_ff;
   mlpq_pkg::status_type                 rsp_status_ff;
   logic [mlpq_pkg::WORD_BITS-1:0]       rsp_value_ff;
   logic [mlpq_pkg::LEVEL_BITS-1:0]      rsp_level_ff;

   logic                                 found;
   logic [mlpq_pkg::LEVEL_BITS-1:0]      pick;
   logic                                 level_ok;
   logic                                 full;
   logic                                 do_insert;
   logic                                 do_remove;
   logic [mlpq_pkg::SLOT_BITS-1:0]       wr_addr;
   logic [mlpq_pkg::SLOT_BITS-1:0]       rd_addr;

   function automatic logic [mlpq_pkg::PTR_BITS-1:0] next_ptr(
      input logic [mlpq_pkg::PTR_BITS-1:0] p
   );
      logic [mlpq_pkg::PTR_BITS-1:0] r;
      if (p == mlpq_pkg::PTR_BITS'(mlpq_pkg::DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // lowest-numbered non-empty level
   always_comb begin
      found = 1'b0;
      pick  = '0;
      for (int i = mlpq_pkg::LEVELS - 1; i >= 0; i--) begin
         if (fill_ff[i] != '0) begin
            found = 1'b1;
            pick  = mlpq_pkg::LEVEL_BITS'(i);
         end
      end
   end

   assign level_ok  = (32'(level_ff) < mlpq_pkg::LEVELS);
   assign full      = (fill_ff[level_ff] >= mlpq_pkg::CNT_BITS'(mlpq_pkg::DEPTH));
   assign do_insert = cmd.exec && (func_ff == mlpq_pkg::FUNC_INSERT) && level_ok && !full;
   assign do_remove = cmd.exec && (func_ff == mlpq_pkg::FUNC_REMOVE) && found;
   assign wr_addr   = mlpq_pkg::SLOT_BITS'(level_ff) * mlpq_pkg::SLOT_BITS'(mlpq_pkg::DEPTH)
                      + mlpq_pkg::SLOT_BITS'(tail_ff[level_ff]);
   assign rd_addr   = mlpq_pkg::SLOT_BITS'(pick) * mlpq_pkg::SLOT_BITS'(mlpq_pkg::DEPTH)
                      + mlpq_pkg::SLOT_BITS'(head_ff[pick]);

   always_comb begin
      if (func_ff == mlpq_pkg::FUNC_INSERT) begin
         status_in = (level_ok && !full) ? mlpq_pkg::STATUS_INSERTED
                                         : mlpq_pkg::STATUS_OVERFLOW;
      end else begin
         status_in = found ? mlpq_pkg::STATUS_REMOVED : mlpq_pkg::STATUS_UNDERFLOW;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         level_ff <= req_level;
         value_ff <= req_value;
      end
   end

   // slot memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (do_insert) begin
         slot_mem[wr_addr] <= value_ff;
      end
      if (do_remove) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         from_ff   <= pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mlpq_pkg::LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         if (do_insert) begin
            tail_ff[level_ff] <= next_ptr(tail_ff[level_ff]);
            fill_ff[level_ff] <= fill_ff[level_ff] + 1'b1;
         end
         if (do_remove) begin
            head_ff[pick] <= next_ptr(head_ff[pick]);
            fill_ff[pick] <= fill_ff[pick] - 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= status_ff;
         if (status_ff == mlpq_pkg::STATUS_REMOVED) begin
            rsp_value_ff <= rd_data_ff;
            rsp_level_ff <= from_ff;
         end else begin
            rsp_value_ff <= '0;
            rsp_level_ff <= '0;
         end
      end
   end

   assign dp_stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_level        = rsp_level_ff;

endmodule

[design/multi_level_priority_queue.sv]
// Top level of the multi-level priority queue: controller plus datapath.
//
//   channel  direction  fields
//   req_     in         tuser: func; tdata: level, item_value
//   rsp_     out        tuser: status; tdata: out_value, out_level
//
// One item at a time: accept, then update the level's pointers and count and write
// the slot or read the head slot into the memory's output register, then load the
// result register. The next item is still accepted while the result register waits
// to be taken, but its own result is held in ST_EMIT until that register is free.
// Synchronous reset empties all levels at once through the per-level counts;
// the slot memory itself is not cleared.
module multi_level_priority_queue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic                                   req_tuser,  // [0] func
   input  logic [mlpq_pkg::REQ_TDATA_BITS-1:0]    req_tdata,  // [1:0] level, [33:2] item_value
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [1:0]                             rsp_tuser,  // [1:0] status
   output logic [mlpq_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata   // [31:0] out_value, [33:32] out_level
);

   localparam int LB = mlpq_pkg::LEVEL_BITS;
   localparam int WB = mlpq_pkg::WORD_BITS;

   mlpq_pkg::cmd_type     cmd;
   mlpq_pkg::dp_stat_type dp_stat;

   logic signed [WB-1:0]  rsp_value;
   logic [LB-1:0]         rsp_level;

   mlpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_stat    (dp_stat),
      .cmd        (cmd)
   );

   mlpq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dp_stat    (dp_stat),
      .req_func   (req_tuser),
      .req_level  (req_tdata[LB-1:0]),
      .req_value  (req_tdata[LB+WB-1:LB]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_value  (rsp_value),
      .rsp_level  (rsp_level)
   );

   // pack result fields, pad with zeros to whole bytes
   assign rsp_tdata = {{(mlpq_pkg::RSP_TDATA_BITS - WB - LB){1'b0}}, rsp_level, rsp_value};

endmodule

[design/mlpq_checker.sv]
// Port-level checker of the multi-level priority queue and its bind.
module mlpq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [1:0]                          rsp_tuser,
   input logic [mlpq_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one item in flight: no accept right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while another is in flight");

   // only a removal carries a word and a level
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != mlpq_pkg::STATUS_REMOVED) |-> (rsp_tdata == '0))
      else $error("non-removal result carries data");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind multi_level_priority_queue mlpq_checker u_mlpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

[test/multi_level_priority_queue_tb.sv]
// Self-checking testbench of the multi-level priority queue: directed table, then random traffic.
module multi_level_priority_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Watchdog limit on cycles without any handshake. The longest legal quiet stretch is
   // the receiver hold-off below, so this leaves a wide margin.
   localparam int IDLE_LIMIT     = 1000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int CHUNKS         = 15;
   localparam int CHUNK_ITEMS    = 50;
   localparam int HOLD_AT_RESULT = 250;   // result count at which the receiver holds off
   localparam int HOLD_CYCLES    = 200;

   typedef struct packed {
      mlpq_pkg::status_type                  status;
      logic [mlpq_pkg::WORD_BITS-1:0]        value;
      logic [mlpq_pkg::LEVEL_BITS-1:0]       level;
   } queue_result_type;

   typedef struct packed {
      mlpq_pkg::func_type                    func;
      logic [mlpq_pkg::LEVEL_BITS-1:0]       level;
      logic [mlpq_pkg::WORD_BITS-1:0]        value;
      logic                                  fixed;   // use the typed-in result instead
      queue_result_type                      want;
   } stim_row_type;

   logic                                     clock;
   logic                                     reset      = 1'b1;
   logic                                     req_tvalid = 1'b0;
   logic                                     req_tready;
   logic                                     req_tuser  = 1'b0;   // [0] func
   logic [mlpq_pkg::REQ_TDATA_BITS-1:0]      req_tdata  = '0;     // [1:0] level, [33:2] item_value
   logic                                     rsp_tvalid;
   logic                                     rsp_tready = 1'b0;
   logic [1:0]                               rsp_tuser;           // [1:0] status
   logic [mlpq_pkg::RSP_TDATA_BITS-1:0]      rsp_tdata;           // [31:0] out_value, [33:32] out_level

   // Shadow copy of the queue: one circular buffer per level in a shared slot array.
   logic [mlpq_pkg::WORD_BITS-1:0]           slot_copy  [mlpq_pkg::SLOTS];
   int unsigned                              head_ptr   [mlpq_pkg::LEVELS] = '{default: 0};
   int unsigned                              tail_ptr   [mlpq_pkg::LEVELS] = '{default: 0};
   int unsigned                              word_count [mlpq_pkg::LEVELS] = '{default: 0};

   queue_result_type                         pending_results[$];
   int                                       mismatches  = 0;
   int                                       idle_cycles = 0;
   bit                                       calm_phase  = 1'b0;  // no gaps on either side

   multi_level_priority_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one operation to the shadow queue and return the result it must give.
   function automatic queue_result_type apply_queue_op(
      mlpq_pkg::func_type                  func,
      logic [mlpq_pkg::LEVEL_BITS-1:0]     lvl,
      logic [mlpq_pkg::WORD_BITS-1:0]      word
   );
      queue_result_type r;
      int               src;
      r   = '{status: mlpq_pkg::STATUS_INSERTED, value: '0, level: '0};
      src = -1;
      if (func == mlpq_pkg::FUNC_INSERT) begin
         // refuse the insert when the level is full (or beyond the last level)
         if (lvl >= mlpq_pkg::LEVELS || word_count[lvl] >= mlpq_pkg::DEPTH) begin
            r.status = mlpq_pkg::STATUS_OVERFLOW;
         end else begin
            slot_copy[lvl * mlpq_pkg::DEPTH + tail_ptr[lvl]] = word;
            tail_ptr[lvl] = (tail_ptr[lvl] + 1) % mlpq_pkg::DEPTH;
            word_count[lvl]++;
         end
      end else begin
         // pick the lowest-numbered level that holds a word
         for (int i = mlpq_pkg::LEVELS - 1; i >= 0; i--) begin
            if (word_count[i] != 0) src = i;
         end
         if (src < 0) begin
            r.status = mlpq_pkg::STATUS_UNDERFLOW;
         end else begin
            r.status = mlpq_pkg::STATUS_REMOVED;
            r.value  = slot_copy[src * mlpq_pkg::DEPTH + head_ptr[src]];
            r.level  = mlpq_pkg::LEVEL_BITS'(src);
            head_ptr[src] = (head_ptr[src] + 1) % mlpq_pkg::DEPTH;
            word_count[src]--;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [mlpq_pkg::WORD_BITS-1:0] got,
                                  logic [mlpq_pkg::WORD_BITS-1:0] want);
      mismatches++;
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
   endtask

   // Offer one item after a random gap, hold it until accepted, then record its expected result.
   // Handshakes are sampled at the falling edge, where every signal has settled.
   task automatic offer_item(mlpq_pkg::func_type func, logic [mlpq_pkg::LEVEL_BITS-1:0] lvl,
                             logic [mlpq_pkg::WORD_BITS-1:0] word, logic fixed,
                             queue_result_type want);
      int               gap;
      logic             took;
      queue_result_type predicted;
      gap = calm_phase ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= mlpq_pkg::REQ_TDATA_BITS'({word, lvl});
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      // advance the shadow queue on every accepted item, typed-in rows included
      predicted = apply_queue_op(func, lvl, word);
      pending_results.push_back(fixed ? want : predicted);
   endtask

   // Result side: stall at random, hold off once for a long stretch so the block backs up,
   // and check every result against the oldest expectation.
   initial begin : result_sink
      int                                 stall;
      int                                 taken;
      logic                               took;
      mlpq_pkg::status_type               got_status;
      logic [mlpq_pkg::WORD_BITS-1:0]     got_value;
      logic [mlpq_pkg::LEVEL_BITS-1:0]    got_level;
      queue_result_type                   want;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AT_RESULT) begin
            // hold off while the sender keeps offering items
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = calm_phase ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do begin
            @(negedge clock);
            took       = rsp_tvalid;
            got_status = mlpq_pkg::status_type'(rsp_tuser);
            got_value  = rsp_tdata[mlpq_pkg::WORD_BITS-1:0];
            got_level  = rsp_tdata[mlpq_pkg::WORD_BITS +: mlpq_pkg::LEVEL_BITS];
            @(posedge clock);
         end while (!took);
         taken++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, status/value", {30'd0, got_status}, got_value);
         end else begin
            want = pending_results.pop_front();
            if (got_status !== want.status)
               report_mismatch("status", {30'd0, got_status}, {30'd0, want.status});
            if (got_value !== want.value)
               report_mismatch("out_value", got_value, want.value);
            if (got_level !== want.level)
               report_mismatch("out_level", {30'd0, got_level}, {30'd0, want.level});
         end
      end
   end

   // Watchdog: end the run when no handshake happens for too long.
   always @(negedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("multi_level_priority_queue test failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      stim_row_type                       rows[$];
      int                                 insert_pct;
      int                                 hot_pct;
      logic [mlpq_pkg::LEVEL_BITS-1:0]    hot_level;
      mlpq_pkg::func_type                 func;
      logic [mlpq_pkg::LEVEL_BITS-1:0]    lvl;
      logic [mlpq_pkg::WORD_BITS-1:0]     word;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. Remove from the empty queue, then the word extremes on the outer
      // levels, priority across levels, and a full level refusing one more word.
      rows.push_back('{mlpq_pkg::FUNC_REMOVE, 2'd0, 32'h0000_0000, 1'b1,
                       '{mlpq_pkg::STATUS_UNDERFLOW, 32'h0000_0000, 2'd0}});
      rows.push_back('{mlpq_pkg::FUNC_INSERT, 2'd3, 32'h8000_0000, 1'b1,
                       '{mlpq_pkg::STATUS_INSERTED, 32'h0000_0000, 2'd0}});
      rows.push_back('{mlpq_pkg::FUNC_INSERT, 2'd0, 32'h7FFF_FFFF, 1'b1,
                       '{mlpq_pkg::STATUS_INSERTED, 32'h0000_0000, 2'd0}});
      rows.push_back('{mlpq_pkg::FUNC_INSERT, 2'd2, 32'hFFFF_FFFF, 1'b0, '0});
      rows.push_back('{mlpq_pkg::FUNC_REMOVE, 2'd3, 32'hDEAD_BEEF, 1'b1,
                       '{mlpq_pkg::STATUS_REMOVED, 32'h7FFF_FFFF, 2'd0}});
      rows.push_back('{mlpq_pkg::FUNC_REMOVE, 2'd1, 32'h1234_5678, 1'b0, '0});
      rows.push_back('{mlpq_pkg::FUNC_REMOVE, 2'd0, 32'hFFFF_FFFF, 1'b1,
                       '{mlpq_pkg::STATUS_REMOVED, 32'h8000_0000, 2'd3}});
      rows.push_back('{mlpq_pkg::FUNC_REMOVE, 2'd2, 32'h0000_0000, 1'b1,
                       '{mlpq_pkg::STATUS_UNDERFLOW, 32'h0000_0000, 2'd0}});
      for (int i = 0; i < mlpq_pkg::DEPTH; i++) begin
         rows.push_back('{mlpq_pkg::FUNC_INSERT, 2'd1, 32'h1111_1111 * i ^ 32'hA5A5_0000,
                          1'b0, '0});
      end
      rows.push_back('{mlpq_pkg::FUNC_INSERT, 2'd1, 32'h0000_0000, 1'b1,
                       '{mlpq_pkg::STATUS_OVERFLOW, 32'h0000_0000, 2'd0}});
      rows.push_back('{mlpq_pkg::FUNC_REMOVE, 2'd0, 32'h0000_0000, 1'b0, '0});

      foreach (rows[i]) begin
         offer_item(rows[i].func, rows[i].level, rows[i].value, rows[i].fixed, rows[i].want);
      end

      // Random part in chunks: each chunk picks an insert bias and a hot level, so the run
      // swings between full levels, overflow, draining and underflow; some chunks run calm.
      for (int c = 0; c < CHUNKS; c++) begin
         case ($urandom_range(0, 3))
            0: begin
               insert_pct = 15;
            end
            1: begin
               insert_pct = 50;
            end
            2: begin
               insert_pct = 85;
            end
            default: begin
               insert_pct = 100;
            end
         endcase
         hot_level  = mlpq_pkg::LEVEL_BITS'($urandom_range(0, mlpq_pkg::LEVELS - 1));
         hot_pct    = $urandom_range(0, 100);
         calm_phase = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < CHUNK_ITEMS; k++) begin
            func = ($urandom_range(1, 100) <= insert_pct) ? mlpq_pkg::FUNC_INSERT
                                                          : mlpq_pkg::FUNC_REMOVE;
            lvl  = ($urandom_range(1, 100) <= hot_pct)
                   ? hot_level : mlpq_pkg::LEVEL_BITS'($urandom_range(0, 3));
            case ($urandom_range(0, 15))
               0: begin
                  word = 32'h8000_0000;
               end
               1: begin
                  word = 32'h7FFF_FFFF;
               end
               2: begin
                  word = 32'h0000_0000;
               end
               3: begin
                  word = 32'hFFFF_FFFF;
               end
               default: begin
                  word = $urandom;
               end
            endcase
            offer_item(func, lvl, word, 1'b0, '0);
         end
      end
      calm_phase = 1'b0;

      // drop valid at the last acceptance, then drain the result side
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("multi_level_priority_queue test passed");
      end else begin
         $display("multi_level_priority_queue test failed");
      end
      $finish;
   end

endmodule
